FILE: hw/rtl/fre_pkg.sv
package fre_pkg;

  localparam int ADDR_W      = 32;
  localparam int SECTOR_LOG2 = 12;
  localparam int BLOCK_LOG2  = 16;
  localparam int SECTOR_BYTES = 1 << SECTOR_LOG2;
  localparam int BLOCK_BYTES  = 1 << BLOCK_LOG2;
  localparam int CNT_W        = ADDR_W - BLOCK_LOG2;

  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

  localparam logic [1:0] KIND_SECTOR = 2'd0;
  localparam logic [1:0] KIND_BLOCK  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEAD   = 4'b0010,
    PH_MIDDLE = 4'b0100,
    PH_TAIL   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] byte_count;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        erase_kind;
    logic [ADDR_W-1:0] erase_address;
    logic              last;
  } out_word_t;

  typedef struct packed {
    phase_t            phase;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] rest;
  } plan_t;

  typedef struct packed {
    logic  mode;
    plan_t plan;
  } cmd_word_t;

  // first non-empty phase from addr with size bytes to go
  function automatic plan_t plan_from(input logic head_ok, input logic mid_ok,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [ADDR_W-1:0] size);
    plan_t                 p;
    logic [BLOCK_LOG2-1:0] off;
    logic [BLOCK_LOG2:0]   room;
    logic [BLOCK_LOG2:0]   head;
    logic [BLOCK_LOG2+1:0] sum;
    off  = addr[BLOCK_LOG2-1:0];
    room = (BLOCK_LOG2+1)'(BLOCK_BYTES) - {1'b0, off};
    head = (ADDR_W'(room) > size) ? size[BLOCK_LOG2:0] : room;
    p.phase    = PH_IDLE;
    p.addr     = '0;
    p.cnt      = '0;
    p.end_addr = '0;
    p.rest     = '0;
    if (head_ok && off != '0 && size != '0) begin
      sum        = {1'b0, head} + (BLOCK_LOG2+2)'(SECTOR_BYTES - 1);
      p.phase    = PH_HEAD;
      p.addr     = addr;
      p.cnt      = CNT_W'(sum >> SECTOR_LOG2);
      p.end_addr = addr + ADDR_W'(head);
      p.rest     = size - ADDR_W'(head);
    end else if (mid_ok && size > ADDR_W'(BLOCK_BYTES)) begin
      p.phase    = PH_MIDDLE;
      p.addr     = addr;
      p.cnt      = size[ADDR_W-1:BLOCK_LOG2];
      p.end_addr = addr + {size[ADDR_W-1:BLOCK_LOG2], {BLOCK_LOG2{1'b0}}};
      p.rest     = {{(ADDR_W-BLOCK_LOG2){1'b0}}, size[BLOCK_LOG2-1:0]};
    end else if (size != '0) begin
      // tail never exceeds one block here
      sum        = {1'b0, size[BLOCK_LOG2:0]} + (BLOCK_LOG2+2)'(SECTOR_BYTES - 1);
      p.phase    = PH_TAIL;
      p.addr     = addr;
      p.cnt      = CNT_W'(sum >> SECTOR_LOG2);
      p.end_addr = addr;
      p.rest     = '0;
    end
    return p;
  endfunction

endpackage

FILE: hw/rtl/fre_fifo.sv
module fre_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/fre_front.sv
module fre_front (
  input  logic                 in_push,
  input  fre_pkg::in_word_t    in_word,
  input  logic                 q_full,
  output logic                 q_push,
  output fre_pkg::cmd_word_t   q_word
);

  // start words are planned here, next words pass through
  always_comb begin
    q_word.mode = in_word.mode;
    if (in_word.mode == fre_pkg::MODE_START) begin
      q_word.plan = fre_pkg::plan_from(1'b1, 1'b1, in_word.start_address,
                                       in_word.byte_count);
    end else begin
      q_word.plan.phase    = fre_pkg::PH_IDLE;
      q_word.plan.addr     = '0;
      q_word.plan.cnt      = '0;
      q_word.plan.end_addr = '0;
      q_word.plan.rest     = '0;
    end
  end

  assign q_push = in_push & ~q_full;

endmodule

FILE: hw/rtl/fre_back.sv
module fre_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  fre_pkg::cmd_word_t  q_word,
  output logic                q_pop,
  input  logic                res_full,
  output logic                res_push,
  output fre_pkg::out_word_t  res_word
);

  fre_pkg::plan_t plan_r, plan_nxt;
  fre_pkg::plan_t cur;
  fre_pkg::plan_t after;
  fre_pkg::plan_t idle_plan;
  logic           fire;
  logic           is_block;

  assign fire     = ~q_empty & ~res_full;
  assign q_pop    = fire;
  assign res_push = fire;

  assign cur      = (q_word.mode == fre_pkg::MODE_START) ? q_word.plan : plan_r;
  assign is_block = (cur.phase == fre_pkg::PH_MIDDLE);

  always_comb begin
    idle_plan.phase    = fre_pkg::PH_IDLE;
    idle_plan.addr     = '0;
    idle_plan.cnt      = '0;
    idle_plan.end_addr = '0;
    idle_plan.rest     = '0;
  end

  // step within the current phase, or move to the following one
  always_comb begin
    after      = cur;
    after.addr = cur.addr + (is_block ? fre_pkg::ADDR_W'(fre_pkg::BLOCK_BYTES)
                                      : fre_pkg::ADDR_W'(fre_pkg::SECTOR_BYTES));
    after.cnt  = cur.cnt - 1'b1;
    if (cur.cnt == fre_pkg::CNT_W'(1)) begin
      unique case (cur.phase)
        fre_pkg::PH_HEAD:   after = fre_pkg::plan_from(1'b0, 1'b1, cur.end_addr, cur.rest);
        fre_pkg::PH_MIDDLE: after = fre_pkg::plan_from(1'b0, 1'b0, cur.end_addr, cur.rest);
        fre_pkg::PH_TAIL:   after = idle_plan;
        default:            after = idle_plan;
      endcase
    end
  end

  always_comb begin
    if (cur.phase == fre_pkg::PH_IDLE) begin
      plan_nxt               = cur;
      res_word.erase_kind    = fre_pkg::KIND_NONE;
      res_word.erase_address = '0;
      res_word.last          = 1'b1;
    end else begin
      plan_nxt               = after;
      res_word.erase_kind    = is_block ? fre_pkg::KIND_BLOCK : fre_pkg::KIND_SECTOR;
      res_word.erase_address = cur.addr;
      res_word.last          = (after.phase == fre_pkg::PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_r <= idle_plan;
    end else if (fire) begin
      plan_r <= plan_nxt;
    end
  end

endmodule

FILE: hw/rtl/flash_range_erase_planner_core.sv
// Erase planner: every word pushed in yields exactly one result word. A start
// word (mode 0) plans a new request and returns its first command; a next word
// (mode 1) returns the following command, with last set on the final one and
// on any word that has nothing to erase. Unaligned heads go out as sector
// erases, whole blocks as block erases if more than one block remains, and
// the remainder as sector erases. One word per cycle is sustained while the
// output queue has room. A word is registered in the input queue, and the
// sequencer forms its result in the cycle it leaves that queue, writing it to
// the output queue, so the sequencer's state update sets the rate.
module flash_range_erase_planner_core #(
  parameter int CMD_DEPTH = fre_pkg::CMD_QUEUE_DEPTH,
  parameter int RES_DEPTH = fre_pkg::RES_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  fre_pkg::in_word_t  in_word,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output fre_pkg::out_word_t out_word
);

  fre_pkg::cmd_word_t front_word;
  fre_pkg::cmd_word_t cmd_word;
  fre_pkg::out_word_t res_word;
  logic               front_push;
  logic               cmd_empty;
  logic               cmd_pop;
  logic               res_push;
  logic               res_full;

  fre_front u_front (
    .in_push (in_push),
    .in_word (in_word),
    .q_full  (in_full),
    .q_push  (front_push),
    .q_word  (front_word)
  );

  fre_fifo #(
    .W     ($bits(fre_pkg::cmd_word_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata (front_word),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_word),
    .empty (cmd_empty)
  );

  fre_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (cmd_empty),
    .q_word   (cmd_word),
    .q_pop    (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_word (res_word)
  );

  fre_fifo #(
    .W     ($bits(fre_pkg::out_word_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_word),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_word),
    .empty (out_empty)
  );

endmodule
